@@ hw/rtl/cikl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cikl_pkg
// Shared types, character codes and the keyword table of the C name lexer.
// ----------------------------------------------------------------------------
package cikl_pkg;

  localparam int NAME_CHARS  = 8;
  localparam int NAME_W      = 8 * NAME_CHARS;
  localparam int LANE_W      = $clog2(NAME_CHARS);
  localparam int COUNT_W     = 9;
  localparam int OUT_POS_W   = 16;
  localparam int KW_COUNT    = 32;
  localparam int KW_IDX_W    = 5;
  localparam int POS_WIDTH   = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DATA_W  = 120;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 9'd256;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [1:0] {
    KIND_IDENT   = 2'd0,
    KIND_KEYWORD = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  // One queue entry holds everything one input item causes: an optional
  // finished name and an optional unsupported byte, in that order.
  typedef struct packed {
    logic                 has_name;
    logic                 has_bad;
    logic [NAME_W-1:0]    name_buf;
    logic [COUNT_W-1:0]   name_cnt;
    logic [OUT_POS_W-1:0] name_line;
    logic [OUT_POS_W-1:0] name_col;
    logic [OUT_POS_W-1:0] bad_line;
    logic [OUT_POS_W-1:0] bad_col;
    logic [7:0]           bad_char;
  } entry_t;

  typedef struct packed {
    kind_t                kind;
    logic [KW_IDX_W-1:0]  keyword_index;
    logic [NAME_W-1:0]    name_text;
    logic [7:0]           name_length;
    logic                 length_saturated;
    logic [OUT_POS_W-1:0] start_line;
    logic [OUT_POS_W-1:0] start_column;
    logic [7:0]           bad_char;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic                hit;
    logic [KW_IDX_W-1:0] idx;
  } kw_match_t;

  // Keywords as right-aligned string literals; the lookup reverses them so
  // that the first character sits in the low byte, as in the name buffer.
  localparam logic [NAME_W-1:0] KW_LIT [KW_COUNT] = '{
    64'("auto"),     64'("extern"),   64'("register"), 64'("static"),
    64'("typedef"),  64'("const"),    64'("volatile"), 64'("signed"),
    64'("unsigned"), 64'("short"),    64'("long"),     64'("char"),
    64'("int"),      64'("float"),    64'("double"),   64'("enum"),
    64'("struct"),   64'("union"),    64'("void"),     64'("break"),
    64'("case"),     64'("continue"), 64'("default"),  64'("do"),
    64'("else"),     64'("for"),      64'("goto"),     64'("if"),
    64'("return"),   64'("switch"),   64'("while"),    64'("sizeof")
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd6, 4'd8, 4'd6, 4'd7, 4'd5, 4'd8, 4'd6,
    4'd8, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5, 4'd6, 4'd4,
    4'd6, 4'd5, 4'd4, 4'd5, 4'd4, 4'd8, 4'd7, 4'd2,
    4'd4, 4'd3, 4'd4, 4'd2, 4'd6, 4'd6, 4'd5, 4'd6
  };

  // Parallel compare against all keywords; the keywords are distinct, so at
  // most one compare hits and the index is the OR of the hit positions.
  function automatic kw_match_t kw_lookup(input logic [NAME_W-1:0] text,
                                          input logic [COUNT_W-1:0] count);
    kw_match_t         m;
    logic [NAME_W-1:0] lit;
    logic [NAME_W-1:0] kw_bits;
    logic [3:0]        len;
    m = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      lit     = KW_LIT[i];
      len     = KW_LEN[i];
      kw_bits = '0;
      for (int j = 0; j < NAME_CHARS; j++) begin
        if (4'(j) < len) begin
          kw_bits[8*j +: 8] = lit[8*(int'(len) - 1 - j) +: 8];
        end
      end
      if (count == COUNT_W'(len) && text == kw_bits) begin
        m.hit = 1'b1;
        m.idx = m.idx | KW_IDX_W'(i);
      end
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/cikl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cikl_front
// Accepts source bytes, tracks line, column and the open name, and queues
// the finished name and unsupported byte that each item causes.
// ----------------------------------------------------------------------------
module cikl_front #(
  parameter int POS_WIDTH = cikl_pkg::POS_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  output logic             push,
  output cikl_pkg::entry_t push_data,
  input  logic             queue_full
);

  localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

  logic [POS_WIDTH-1:0]         line_r, line_nxt;
  logic [POS_WIDTH-1:0]         col_r, col_nxt;
  logic                         in_name_r, in_name_nxt;
  logic [cikl_pkg::NAME_W-1:0]  buf_r, buf_nxt, buf_base;
  logic [cikl_pkg::COUNT_W-1:0] cnt_r, cnt_nxt, cnt_base;
  logic [POS_WIDTH-1:0]         sline_r, sline_nxt;
  logic [POS_WIDTH-1:0]         scol_r, scol_nxt;
  logic                         after_cr_r, after_cr_nxt;
  logic                         accept;
  logic                         is_name_char;
  logic                         is_blank;
  logic                         has_name;
  logic                         has_bad;

  function automatic logic [POS_WIDTH-1:0] pos_inc(input logic [POS_WIDTH-1:0] v);
    return (&v) ? v : v + POS_ONE;
  endfunction

  assign in_tready = !queue_full;
  assign accept    = in_tvalid && in_tready;

  assign is_name_char = (in_tdata >= cikl_pkg::CH_UPPER_A && in_tdata <= cikl_pkg::CH_UPPER_Z)
                     || (in_tdata >= cikl_pkg::CH_LOWER_A && in_tdata <= cikl_pkg::CH_LOWER_Z)
                     || (in_tdata == cikl_pkg::CH_USCORE);
  assign is_blank = (in_tdata == cikl_pkg::CH_SPACE) || (in_tdata == cikl_pkg::CH_TAB)
                 || (in_tdata == cikl_pkg::CH_CR) || (in_tdata == cikl_pkg::CH_LF);

  always_comb begin
    line_nxt     = line_r;
    col_nxt      = col_r;
    in_name_nxt  = in_name_r;
    buf_nxt      = buf_r;
    cnt_nxt      = cnt_r;
    sline_nxt    = sline_r;
    scol_nxt     = scol_r;
    after_cr_nxt = 1'b0;
    buf_base     = in_name_r ? buf_r : '0;
    cnt_base     = in_name_r ? cnt_r : '0;

    if (is_name_char) begin
      in_name_nxt = 1'b1;
      if (!in_name_r) begin
        sline_nxt = line_r;
        scol_nxt  = col_r;
      end
      buf_nxt = buf_base;
      for (int i = 0; i < cikl_pkg::NAME_CHARS; i++) begin
        if (cnt_base < cikl_pkg::COUNT_W'(cikl_pkg::NAME_CHARS)
            && cnt_base[cikl_pkg::LANE_W-1:0] == cikl_pkg::LANE_W'(i)) begin
          buf_nxt[8*i +: 8] = in_tdata;
        end
      end
      cnt_nxt = (cnt_base < cikl_pkg::COUNT_SAT) ? cnt_base + 1'b1 : cnt_base;
      col_nxt = pos_inc(col_r);
    end else begin
      in_name_nxt = 1'b0;
      if (in_tdata == cikl_pkg::CH_SPACE || in_tdata == cikl_pkg::CH_TAB) begin
        col_nxt = pos_inc(col_r);
      end else if (in_tdata == cikl_pkg::CH_CR) begin
        line_nxt     = pos_inc(line_r);
        col_nxt      = '0;
        after_cr_nxt = 1'b1;
      end else if (in_tdata == cikl_pkg::CH_LF) begin
        // LF right after CR belongs to the same newline.
        if (!after_cr_r) begin
          line_nxt = pos_inc(line_r);
          col_nxt  = '0;
        end
      end else begin
        col_nxt = pos_inc(col_r);
      end
    end

    // A name closes on any other byte, or on the last byte of the text.
    has_name = in_name_r ? (!is_name_char || in_tlast) : (is_name_char && in_tlast);
    has_bad  = !is_name_char && !is_blank;

    push_data.has_name  = has_name;
    push_data.has_bad   = has_bad;
    push_data.name_buf  = buf_nxt;
    push_data.name_cnt  = cnt_nxt;
    push_data.name_line = cikl_pkg::OUT_POS_W'(sline_nxt);
    push_data.name_col  = cikl_pkg::OUT_POS_W'(scol_nxt);
    push_data.bad_line  = cikl_pkg::OUT_POS_W'(line_r);
    push_data.bad_col   = cikl_pkg::OUT_POS_W'(col_r);
    push_data.bad_char  = in_tdata;

    if (in_tlast) begin
      line_nxt     = POS_ONE;
      col_nxt      = '0;
      in_name_nxt  = 1'b0;
      buf_nxt      = '0;
      cnt_nxt      = '0;
      sline_nxt    = POS_ONE;
      scol_nxt     = '0;
      after_cr_nxt = 1'b0;
    end
  end

  assign push = accept && (has_name || has_bad);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r     <= POS_ONE;
      col_r      <= '0;
      in_name_r  <= 1'b0;
      buf_r      <= '0;
      cnt_r      <= '0;
      sline_r    <= POS_ONE;
      scol_r     <= '0;
      after_cr_r <= 1'b0;
    end else if (accept) begin
      line_r     <= line_nxt;
      col_r      <= col_nxt;
      in_name_r  <= in_name_nxt;
      buf_r      <= buf_nxt;
      cnt_r      <= cnt_nxt;
      sline_r    <= sline_nxt;
      scol_r     <= scol_nxt;
      after_cr_r <= after_cr_nxt;
    end
  end

  a_eot_closes_name: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> !in_name_r && line_r == POS_ONE && cnt_r == '0)
    else $error("name state not cleared after end of text");

endmodule

@@ hw/rtl/cikl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cikl_queue
// Short first-in first-out queue of pending items between front and back.
// ----------------------------------------------------------------------------
module cikl_queue #(
  parameter int DEPTH = cikl_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cikl_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output cikl_pkg::entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cikl_pkg::entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue pushed while full or popped while empty");

endmodule

@@ hw/rtl/cikl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cikl_back
// Takes queued items, looks names up in the keyword table and delivers one
// result per cycle, while items are queued and the output is not held, through an output register.
// ----------------------------------------------------------------------------
module cikl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cikl_pkg::entry_t  q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output cikl_pkg::result_t out_res
);

  logic                 phase_r, phase_nxt;
  logic                 out_valid_r, out_valid_nxt;
  cikl_pkg::result_t    res_r;
  cikl_pkg::result_t    res;
  cikl_pkg::kw_match_t  kw;
  logic                 load;
  logic                 sel_name;

  assign kw       = cikl_pkg::kw_lookup(q_head.name_buf, q_head.name_cnt);
  assign sel_name = !phase_r && q_head.has_name;
  assign load     = !q_empty && (!out_valid_r || out_ready);

  always_comb begin
    if (sel_name) begin
      res.kind             = kw.hit ? cikl_pkg::KIND_KEYWORD : cikl_pkg::KIND_IDENT;
      res.keyword_index    = kw.hit ? kw.idx : '0;
      res.name_text        = q_head.name_buf;
      // The count saturates at 256, so bit 8 alone marks an overlong name.
      res.name_length      = q_head.name_cnt[8] ? 8'hFF : q_head.name_cnt[7:0];
      res.length_saturated = q_head.name_cnt[8];
      res.start_line       = q_head.name_line;
      res.start_column     = q_head.name_col;
      res.bad_char         = '0;
      res.last             = !q_head.has_bad;
    end else begin
      res.kind             = cikl_pkg::KIND_BAD;
      res.keyword_index    = '0;
      res.name_text        = '0;
      res.name_length      = 8'd1;
      res.length_saturated = 1'b0;
      res.start_line       = q_head.bad_line;
      res.start_column     = q_head.bad_col;
      res.bad_char         = q_head.bad_char;
      res.last             = 1'b1;
    end

    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      phase_nxt     = !res.last;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign pop       = load && res.last;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  a_phase_has_bad: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !q_empty && q_head.has_name && q_head.has_bad)
    else $error("second result pending without an unsupported byte at the head");

  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind == cikl_pkg::KIND_BAD |-> res_r.last)
    else $error("unsupported-byte result not marked last");

  a_split_then_bad: assert property (@(posedge clk) disable iff (!rst_n)
    load && !res.last |=> out_valid_r && !q_empty && phase_r)
    else $error("name result split from its byte but second half lost");

endmodule

@@ hw/rtl/c_identifier_keyword_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_identifier_keyword_lexer
// Streaming C name and keyword recognizer: one source byte per item in,
// identifier, keyword and unsupported-byte results out.
// ----------------------------------------------------------------------------
// A taken item is queued, then its result is loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; a byte that
// closes a name and is itself unsupported gives two results, name first,
// which the QUEUE_DEPTH-entry queue between front and back absorbs.
// Reset (rst_n low, synchronous): line 1, column 0, no open name, queue and
// output register empty; no clearing pass is needed.
module c_identifier_keyword_lexer #(
  parameter int POS_WIDTH   = cikl_pkg::POS_WIDTH,
  parameter int QUEUE_DEPTH = cikl_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // ch
  input  logic                            in_tlast,   // end_of_text
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // keyword_index, name_text, name_length, length_saturated, start_line,
  // start_column, bad_char, zero fill
  output logic [cikl_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser,  // kind
  output logic                            out_tlast   // last_of_run
);

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  cikl_pkg::entry_t  push_data;
  cikl_pkg::entry_t  q_head;
  cikl_pkg::result_t res;

  cikl_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push       (push),
    .push_data  (push_data),
    .queue_full (q_full)
  );

  cikl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  cikl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {2'b00, res.bad_char, res.start_column, res.start_line,
                      res.length_saturated, res.name_length, res.name_text,
                      res.keyword_index};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
